>>> sv/dlnp_pkg.sv
// Shared types, constants and character codes for the decimal line number parser.
package dlnp_pkg;

  // Default parameter values.
  localparam int BUF_SIZE_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed sizes of the parse state.
  localparam int MANT_W      = 60;
  localparam int MANT_DIGITS = 18;
  localparam int DIGITS_W    = 5;
  localparam int SHIFT_W     = 8;
  localparam int EXP_W       = 6;
  localparam int EXP_MAX     = 63;
  localparam int E_W         = 10;
  localparam int CNT_W       = 8;
  // Largest negative power of ten that can still give a nonzero result.
  localparam int MAX_DIV_POW = 27;
  // Width that holds 10**MAX_DIV_POW.
  localparam int DEN_W       = 90;

  localparam logic [7:0] END_CHAR_RESET = 8'd10;

  // Character codes.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  typedef enum logic [2:0] {
    PH_START, PH_ZEROS, PH_INT, PH_DOT, PH_FRAC, PH_EXPS, PH_EXPD, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MUL, S_DEN, S_DIV, S_ROUND, S_FIN
  } state_t;

  // Number as parsed so far.
  typedef struct packed {
    logic                      negative;
    logic [MANT_W-1:0]         mantissa;
    logic [DIGITS_W-1:0]       digits;
    logic signed [SHIFT_W-1:0] shift;
    logic                      exp_negative;
    logic [EXP_W-1:0]          exp_magnitude;
  } line_t;

  // Commands from the controller to the conversion datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic take_prod;
    logic set_sat;
    logic den_step;
    logic div_step;
    logic round;
    logic out_load;
  } cmd_t;

  // Status from the conversion datapath to the controller.
  typedef struct packed {
    logic mant_zero;
    logic e_neg;
    logic e_tiny;
    logic cnt_zero;
    logic p_over;
    logic div_last;
  } status_t;

endpackage

>>> sv/dlnp_parser.sv
// Byte-wise parser that builds the mantissa, decimal shift and exponent of one line.
module dlnp_parser #(
  parameter int BUF_SIZE = dlnp_pkg::BUF_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  output logic             line_end,
  output dlnp_pkg::line_t  line
);

  localparam int LC_W = (BUF_SIZE > 2) ? $clog2(BUF_SIZE) : 1;
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(BUF_SIZE - 1);

  logic [7:0]       end_char;
  logic [LC_W-1:0]  line_count;
  dlnp_pkg::phase_t phase, phase_next;
  dlnp_pkg::line_t  line_next;

  // Take one digit into the mantissa, or adjust the decimal shift.
  function automatic dlnp_pkg::line_t take_digit(dlnp_pkg::line_t l, logic [3:0] d,
                                                 logic frac);
    dlnp_pkg::line_t r;
    r = l;
    if (l.digits < dlnp_pkg::DIGITS_W'(dlnp_pkg::MANT_DIGITS)) begin
      if (l.mantissa != '0 || d != 4'd0) begin
        r.mantissa = (l.mantissa << 3) + (l.mantissa << 1) + dlnp_pkg::MANT_W'(d);
        r.digits   = l.digits + 1'b1;
      end
      if (frac && l.shift != -8'sd128) r.shift = l.shift - 8'sd1;
    end else if (!frac && l.shift != 8'sd127) begin
      r.shift = l.shift + 8'sd1;
    end
    return r;
  endfunction

  // Next parse state for one byte.
  always_comb begin
    logic       dig;
    logic       ech;
    logic [3:0] d;
    logic [9:0] e;
    dig = (rx_byte >= dlnp_pkg::CH_ZERO) && (rx_byte <= dlnp_pkg::CH_NINE);
    ech = (rx_byte == dlnp_pkg::CH_E_LO) || (rx_byte == dlnp_pkg::CH_E_UP);
    d   = 4'(rx_byte - dlnp_pkg::CH_ZERO);
    e   = 10'(line.exp_magnitude) * 10'd10 + 10'(d);
    line_next  = line;
    phase_next = phase;
    unique case (phase)
      dlnp_pkg::PH_START, dlnp_pkg::PH_ZEROS: begin
        if (phase == dlnp_pkg::PH_START && rx_byte == dlnp_pkg::CH_MINUS) begin
          line_next.negative = 1'b1;
          phase_next = dlnp_pkg::PH_ZEROS;
        end else if (rx_byte == dlnp_pkg::CH_ZERO) begin
          phase_next = dlnp_pkg::PH_ZEROS;
        end else if (dig) begin
          line_next  = take_digit(line, d, 1'b0);
          phase_next = dlnp_pkg::PH_INT;
        end else if (rx_byte == dlnp_pkg::CH_DOT) begin
          phase_next = dlnp_pkg::PH_DOT;
        end else if (ech) begin
          phase_next = dlnp_pkg::PH_EXPS;
        end else begin
          phase_next = dlnp_pkg::PH_DONE;
        end
      end
      dlnp_pkg::PH_INT: begin
        if (dig) line_next = take_digit(line, d, 1'b0);
        else if (rx_byte == dlnp_pkg::CH_DOT) phase_next = dlnp_pkg::PH_DOT;
        else if (ech) phase_next = dlnp_pkg::PH_EXPS;
        else phase_next = dlnp_pkg::PH_DONE;
      end
      dlnp_pkg::PH_DOT: begin
        if (dig) begin
          line_next  = take_digit(line, d, 1'b1);
          phase_next = dlnp_pkg::PH_FRAC;
        end else begin
          phase_next = dlnp_pkg::PH_DONE;
        end
      end
      dlnp_pkg::PH_FRAC: begin
        if (dig) line_next = take_digit(line, d, 1'b1);
        else if (ech) phase_next = dlnp_pkg::PH_EXPS;
        else phase_next = dlnp_pkg::PH_DONE;
      end
      dlnp_pkg::PH_EXPS: begin
        if (rx_byte == dlnp_pkg::CH_PLUS) begin
          phase_next = dlnp_pkg::PH_EXPD;
        end else if (rx_byte == dlnp_pkg::CH_MINUS) begin
          line_next.exp_negative = 1'b1;
          phase_next = dlnp_pkg::PH_EXPD;
        end else if (dig) begin
          line_next.exp_magnitude = dlnp_pkg::EXP_W'(d);
          phase_next = dlnp_pkg::PH_EXPD;
        end else begin
          phase_next = dlnp_pkg::PH_DONE;
        end
      end
      dlnp_pkg::PH_EXPD: begin
        if (dig) begin
          line_next.exp_magnitude = (e > 10'(dlnp_pkg::EXP_MAX)) ?
                                    dlnp_pkg::EXP_W'(dlnp_pkg::EXP_MAX) : e[5:0];
        end else begin
          phase_next = dlnp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  assign line_end = accept && (rx_byte == end_char);

  // End character register.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_char <= dlnp_pkg::END_CHAR_RESET;
    end else if (cfg_we) begin
      end_char <= cfg_data;
    end
  end

  // Line state: cleared on the end character and on an overlong line.
  always_ff @(posedge clk) begin
    if (rst || line_end || (accept && line_count == LC_LAST)) begin
      line_count <= '0;
      phase      <= dlnp_pkg::PH_START;
      line       <= '0;
    end else if (accept) begin
      line_count <= line_count + 1'b1;
      phase      <= phase_next;
      line       <= line_next;
    end
  end

endmodule

>>> sv/dlnp_datapath.sv
// Conversion datapath: power-of-ten scaling, bit-serial division, rounding and saturation.
module dlnp_datapath #(
  parameter int FRAC_BITS = dlnp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  dlnp_pkg::line_t    line,
  input  dlnp_pkg::cmd_t     cmd,
  output dlnp_pkg::status_t  status,
  output logic signed [31:0] value,
  output logic               saturated
);

  localparam int NUM_W = dlnp_pkg::MANT_W + FRAC_BITS;
  localparam int BIT_W = $clog2(NUM_W + 1);
  localparam int DEN_W = dlnp_pkg::DEN_W;

  logic                         negative;
  logic                         mant_zero;
  logic                         e_neg;
  logic                         e_tiny;
  logic [dlnp_pkg::CNT_W-1:0]   cnt;
  logic [dlnp_pkg::MANT_W-1:0]  p;
  logic [DEN_W-1:0]             den;
  logic [NUM_W-1:0]             num;
  logic [DEN_W-1:0]             rem;
  logic [NUM_W-1:0]             quo;
  logic [BIT_W-1:0]             bitcnt;
  logic [NUM_W-1:0]             mag;
  logic                         sat;

  logic signed [dlnp_pkg::E_W-1:0] e_full;
  logic [dlnp_pkg::E_W-1:0]        e_abs;
  logic [DEN_W:0]                  r2;
  logic [DEN_W:0]                  r2_diff;
  logic                            ge;
  logic [NUM_W-1:0]                lim;
  logic                            sat_all;
  logic [31:0]                     mag32;

  // Total decimal exponent of the parsed number.
  always_comb begin
    e_full = dlnp_pkg::E_W'(line.shift) +
             (line.exp_negative ? -$signed(dlnp_pkg::E_W'(line.exp_magnitude))
                                :  $signed(dlnp_pkg::E_W'(line.exp_magnitude)));
    e_abs  = e_full[dlnp_pkg::E_W-1] ? dlnp_pkg::E_W'(-e_full) : dlnp_pkg::E_W'(e_full);
  end

  // One restoring division step.
  always_comb begin
    r2      = {rem, num[NUM_W-1]};
    r2_diff = r2 - {1'b0, den};
    ge      = !r2_diff[DEN_W] || r2[DEN_W];
  end

  // Saturation limit and signed result.
  always_comb begin
    lim     = {{(NUM_W-32){1'b0}}, negative, {31{~negative}}};
    sat_all = sat || (mag > lim);
    mag32   = sat_all ? lim[31:0] : mag[31:0];
  end

  assign status.mant_zero = mant_zero;
  assign status.e_neg     = e_neg;
  assign status.e_tiny    = e_tiny;
  assign status.cnt_zero  = (cnt == '0);
  assign status.p_over    = (p > dlnp_pkg::MANT_W'(33'h1_0000_0000));
  assign status.div_last  = (bitcnt == BIT_W'(1));

  // Work registers, updated under controller commands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative  <= line.negative;
      mant_zero <= (line.mantissa == '0);
      e_neg     <= e_full[dlnp_pkg::E_W-1];
      e_tiny    <= e_full[dlnp_pkg::E_W-1] &&
                   (e_abs > dlnp_pkg::E_W'(dlnp_pkg::MAX_DIV_POW));
      cnt       <= e_abs[dlnp_pkg::CNT_W-1:0];
      p         <= line.mantissa;
      den       <= DEN_W'(1);
      num       <= NUM_W'(line.mantissa) << FRAC_BITS;
      rem       <= '0;
      quo       <= '0;
      bitcnt    <= BIT_W'(NUM_W);
      mag       <= '0;
      sat       <= 1'b0;
    end
    if (cmd.mul_step) begin
      p   <= (p << 3) + (p << 1);
      cnt <= cnt - 1'b1;
    end
    if (cmd.take_prod) mag <= NUM_W'(p) << FRAC_BITS;
    if (cmd.set_sat) sat <= 1'b1;
    if (cmd.den_step) begin
      den <= (den << 3) + (den << 1);
      cnt <= cnt - 1'b1;
    end
    if (cmd.div_step) begin
      rem    <= ge ? r2_diff[DEN_W-1:0] : r2[DEN_W-1:0];
      quo    <= {quo[NUM_W-2:0], ge};
      num    <= num << 1;
      bitcnt <= bitcnt - 1'b1;
    end
    // Round half up on the remainder.
    if (cmd.round) mag <= quo + NUM_W'({rem, 1'b0} >= {1'b0, den});
    if (cmd.out_load) begin
      value     <= negative ? -$signed(mag32) : $signed(mag32);
      saturated <= sat_all;
    end
  end

endmodule

>>> sv/dlnp_ctrl.sv
// Controller state machine that sequences the conversion of one line.
module dlnp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              line_end,
  input  logic              out_stall,
  input  dlnp_pkg::status_t status,
  output dlnp_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);

  dlnp_pkg::state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dlnp_pkg::S_IDLE: if (line_end) state_next = dlnp_pkg::S_DECIDE;
      dlnp_pkg::S_DECIDE: begin
        if (status.mant_zero || status.e_tiny) state_next = dlnp_pkg::S_FIN;
        else if (!status.e_neg) state_next = dlnp_pkg::S_MUL;
        else state_next = dlnp_pkg::S_DEN;
      end
      dlnp_pkg::S_MUL: if (status.p_over || status.cnt_zero) state_next = dlnp_pkg::S_FIN;
      dlnp_pkg::S_DEN: if (status.cnt_zero) state_next = dlnp_pkg::S_DIV;
      dlnp_pkg::S_DIV: if (status.div_last) state_next = dlnp_pkg::S_ROUND;
      dlnp_pkg::S_ROUND: state_next = dlnp_pkg::S_FIN;
      dlnp_pkg::S_FIN: if (!out_valid || !out_stall) state_next = dlnp_pkg::S_IDLE;
      default: state_next = dlnp_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd      = '0;
    cmd.load = line_end;
    unique case (state)
      dlnp_pkg::S_MUL: begin
        if (status.p_over) cmd.set_sat = 1'b1;
        else if (status.cnt_zero) cmd.take_prod = 1'b1;
        else cmd.mul_step = 1'b1;
      end
      dlnp_pkg::S_DEN:   cmd.den_step = !status.cnt_zero;
      dlnp_pkg::S_DIV:   cmd.div_step = 1'b1;
      dlnp_pkg::S_ROUND: cmd.round = 1'b1;
      dlnp_pkg::S_FIN:   cmd.out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign in_stall = (state != dlnp_pkg::S_IDLE);

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlnp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_end_only_idle: assert property (@(posedge clk) disable iff (rst)
    line_end |-> state == dlnp_pkg::S_IDLE) else $error("line end outside idle");
  a_end_starts: assert property (@(posedge clk) disable iff (rst)
    line_end |=> state == dlnp_pkg::S_DECIDE) else $error("conversion did not start");
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_step, cmd.den_step, cmd.div_step, cmd.round, cmd.out_load}))
    else $error("conflicting datapath steps");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall)) else $error("result overwritten");
`endif

endmodule

>>> sv/decimal_line_number_parser.sv
// Decimal line number parser: one result in signed fixed point per line of received bytes.
// Each byte other than the end character is parsed on the fly as it is taken.
// The end character starts a conversion during which no byte is taken: a decision
// state, then either up to ten multiply-by-ten steps and a step that takes the product
// or flags saturation for a nonnegative exponent, or up to 27 steps that build the
// power-of-ten divisor plus a step that ends that build, one numerator bit per cycle
// (60 + FRAC_BITS bits, 76 by default) in the restoring divider and a rounding step,
// and a final state that writes the output register; a zero mantissa or too small an
// exponent goes straight there. The divider path is the worst case, and the final
// state waits while a previous result still waits in the output register. A result
// left waiting once written does not block the parsing of the next line.
module decimal_line_number_parser #(
  parameter int BUF_SIZE  = dlnp_pkg::BUF_SIZE_DEF,
  parameter int FRAC_BITS = dlnp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         end_char
);

  logic              accept;
  logic              line_end;
  dlnp_pkg::line_t   line;
  dlnp_pkg::cmd_t    cmd;
  dlnp_pkg::status_t status;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  dlnp_parser #(.BUF_SIZE(BUF_SIZE)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (end_char),
    .line_end (line_end),
    .line     (line)
  );

  dlnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .line_end  (line_end),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  dlnp_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .line      (line),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .saturated (saturated)
  );

endmodule
